// File: hw/rtl/mexp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, state and command types for the modular exponentiation unit.
package mexp_pkg;

    localparam int FIELD_W           = 64;
    localparam int OPERAND_WIDTH_DEF = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DIV_WB,
        ST_EXP,
        ST_MUL_A,
        ST_ACC_WB,
        ST_MUL_S,
        ST_SQ_WB,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,          // capture request operands
        OP_DIV_START,     // remainder <= 0, step count <= 0
        OP_DIV_STEP,      // one restoring division bit
        OP_SQ_WB,         // sq <= remainder
        OP_MUL_ACC_START, // product of acc and sq
        OP_MUL_SQ_START,  // product of sq and sq
        OP_MUL_STEP,      // one shift-add bit
        OP_ACC_WB,        // acc <= product, then start squaring
        OP_SQ_SHIFT,      // sq <= product, exponent >>= 1
        OP_OUT            // load the result register
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic step_last;
        logic expo_zero;
        logic expo_lsb;
        logic mod_special;
    } sts_t;

endpackage

// File: hw/rtl/mexp_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces.
interface mexp_req_if;
    logic                          valid;
    logic                          ready;
    logic [mexp_pkg::FIELD_W-1:0]  base_value;
    logic [mexp_pkg::FIELD_W-1:0]  exponent;
    logic [mexp_pkg::FIELD_W-1:0]  modulus;

    modport source (output valid, base_value, exponent, modulus, input ready);
    modport sink   (input valid, base_value, exponent, modulus, output ready);
endinterface

interface mexp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mexp_pkg::FIELD_W-1:0]  power_result;
    logic                          zero_modulus_error;

    modport source (output valid, power_result, zero_modulus_error, input ready);
    modport sink   (input valid, power_result, zero_modulus_error, output ready);
endinterface

// File: hw/rtl/mexp_datapath.sv
`timescale 1ns / 1ps
// Datapath: operand registers, shared shift-add modular multiplier and divider step.
module mexp_datapath #(
    parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mexp_pkg::cmd_t               cmd,
    output mexp_pkg::sts_t               sts,
    input  logic [mexp_pkg::FIELD_W-1:0] base_value,
    input  logic [mexp_pkg::FIELD_W-1:0] exponent,
    input  logic [mexp_pkg::FIELD_W-1:0] modulus,
    output logic [mexp_pkg::FIELD_W-1:0] power_result,
    output logic                         zero_modulus_error
);

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     expo_reg,   expo_next;
    logic [W-1:0]     mod_reg,    mod_next;
    logic [W-1:0]     acc_reg,    acc_next;
    logic [W-1:0]     sq_reg,     sq_next;
    logic [W-1:0]     prod_reg,   prod_next;   // product / remainder
    logic [W-1:0]     mula_reg,   mula_next;   // multiplicand
    logic [W-1:0]     bits_reg,   bits_next;   // multiplier or dividend bits, MSB first
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic [W-1:0]     res_reg,    res_next;
    logic             err_reg,    err_next;

    logic [W:0]       dbl_sum;
    logic [W-1:0]     dbl_mod;
    logic [W:0]       add_sum;
    logic [W-1:0]     add_mod;
    logic [W-1:0]     mul_step;
    logic [W:0]       div_shift;
    logic [W-1:0]     div_step;
    logic             mod_zero;
    logic             mod_one;

    // One shift-add step: prod = 2*prod mod m, then + a mod m when the bit is set.
    always_comb
    begin
        dbl_sum = {1'b0, prod_reg} + {1'b0, prod_reg};
        dbl_mod = (dbl_sum >= {1'b0, mod_reg}) ? W'(dbl_sum - {1'b0, mod_reg}) : W'(dbl_sum);
        add_sum = {1'b0, dbl_mod} + {1'b0, mula_reg};
        add_mod = (add_sum >= {1'b0, mod_reg}) ? W'(add_sum - {1'b0, mod_reg}) : W'(add_sum);
        mul_step = bits_reg[W-1] ? add_mod : dbl_mod;
    end

    // Restoring division step for the base reduction.
    always_comb
    begin
        div_shift = {prod_reg, bits_reg[W-1]};
        div_step  = (div_shift >= {1'b0, mod_reg}) ? W'(div_shift - {1'b0, mod_reg})
                                                     : W'(div_shift);
    end

    assign mod_zero = (mod_reg == '0);
    assign mod_one  = (mod_reg == W'(1));

    always_comb
    begin
        expo_next = expo_reg;
        mod_next  = mod_reg;
        acc_next  = acc_reg;
        sq_next   = sq_reg;
        prod_next = prod_reg;
        mula_next = mula_reg;
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        res_next  = res_reg;
        err_next  = err_reg;
        case (cmd.op)
            mexp_pkg::OP_LOAD:
            begin
                bits_next = base_value[W-1:0];
                expo_next = exponent[W-1:0];
                mod_next  = modulus[W-1:0];
                acc_next  = W'(1);
            end
            mexp_pkg::OP_DIV_START:
            begin
                prod_next = '0;
                cnt_next  = '0;
            end
            mexp_pkg::OP_DIV_STEP:
            begin
                prod_next = div_step;
                bits_next = bits_reg << 1;
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            mexp_pkg::OP_SQ_WB:
            begin
                sq_next = prod_reg;
            end
            mexp_pkg::OP_MUL_ACC_START:
            begin
                prod_next = '0;
                mula_next = acc_reg;
                bits_next = sq_reg;
                cnt_next  = '0;
            end
            mexp_pkg::OP_MUL_SQ_START:
            begin
                prod_next = '0;
                mula_next = sq_reg;
                bits_next = sq_reg;
                cnt_next  = '0;
            end
            mexp_pkg::OP_MUL_STEP:
            begin
                prod_next = mul_step;
                bits_next = bits_reg << 1;
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            mexp_pkg::OP_ACC_WB:
            begin
                acc_next  = prod_reg;
                prod_next = '0;
                mula_next = sq_reg;
                bits_next = sq_reg;
                cnt_next  = '0;
            end
            mexp_pkg::OP_SQ_SHIFT:
            begin
                sq_next   = prod_reg;
                expo_next = expo_reg >> 1;
            end
            mexp_pkg::OP_OUT:
            begin
                err_next = mod_zero;
                res_next = (mod_zero || mod_one) ? '0 : acc_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        expo_reg <= expo_next;
        mod_reg  <= mod_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        prod_reg <= prod_next;
        mula_reg <= mula_next;
        bits_reg <= bits_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
        err_reg  <= err_next;
    end

    assign sts.step_last   = (cnt_reg == CNT_W'(W - 1));
    assign sts.expo_zero   = (expo_reg == '0);
    assign sts.expo_lsb    = expo_reg[0];
    assign sts.mod_special = mod_zero || mod_one;

    assign power_result       = mexp_pkg::FIELD_W'(res_reg);
    assign zero_modulus_error = err_reg;

    // Every division and multiply step leaves its partial value below the modulus.
    a_div_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == mexp_pkg::OP_DIV_STEP |=> prod_reg < mod_reg)
        else $error("remainder not below modulus after division step");

    a_mul_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == mexp_pkg::OP_MUL_STEP |=> prod_reg < mod_reg)
        else $error("partial product not below modulus after multiply step");

endmodule

// File: hw/rtl/mexp_controller.sv
`timescale 1ns / 1ps
// Controller: sequences division, multiplies and result handoff.
module mexp_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mexp_pkg::cmd_t cmd,
    input  mexp_pkg::sts_t sts
);

    mexp_pkg::state_t state_reg, state_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             out_free;

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mexp_pkg::ST_IDLE:
                if (req_valid)
                    state_next = mexp_pkg::ST_CHECK;
            mexp_pkg::ST_CHECK:
                state_next = sts.mod_special ? mexp_pkg::ST_DONE : mexp_pkg::ST_DIV;
            mexp_pkg::ST_DIV:
                if (sts.step_last)
                    state_next = mexp_pkg::ST_DIV_WB;
            mexp_pkg::ST_DIV_WB:
                state_next = mexp_pkg::ST_EXP;
            mexp_pkg::ST_EXP:
                if (sts.expo_zero)
                    state_next = mexp_pkg::ST_DONE;
                else if (sts.expo_lsb)
                    state_next = mexp_pkg::ST_MUL_A;
                else
                    state_next = mexp_pkg::ST_MUL_S;
            mexp_pkg::ST_MUL_A:
                if (sts.step_last)
                    state_next = mexp_pkg::ST_ACC_WB;
            mexp_pkg::ST_ACC_WB:
                state_next = mexp_pkg::ST_MUL_S;
            mexp_pkg::ST_MUL_S:
                if (sts.step_last)
                    state_next = mexp_pkg::ST_SQ_WB;
            mexp_pkg::ST_SQ_WB:
                state_next = mexp_pkg::ST_EXP;
            mexp_pkg::ST_DONE:
                if (out_free)
                    state_next = mexp_pkg::ST_IDLE;
            default:
                state_next = mexp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op         = mexp_pkg::OP_NONE;
        req_ready      = 1'b0;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                    cmd.op = mexp_pkg::OP_LOAD;
            end
            mexp_pkg::ST_CHECK:
                if (!sts.mod_special)
                    cmd.op = mexp_pkg::OP_DIV_START;
            mexp_pkg::ST_DIV:
                cmd.op = mexp_pkg::OP_DIV_STEP;
            mexp_pkg::ST_DIV_WB:
                cmd.op = mexp_pkg::OP_SQ_WB;
            mexp_pkg::ST_EXP:
                if (!sts.expo_zero)
                    cmd.op = sts.expo_lsb ? mexp_pkg::OP_MUL_ACC_START
                                          : mexp_pkg::OP_MUL_SQ_START;
            mexp_pkg::ST_MUL_A,
            mexp_pkg::ST_MUL_S:
                cmd.op = mexp_pkg::OP_MUL_STEP;
            mexp_pkg::ST_ACC_WB:
                cmd.op = mexp_pkg::OP_ACC_WB;
            mexp_pkg::ST_SQ_WB:
                cmd.op = mexp_pkg::OP_SQ_SHIFT;
            mexp_pkg::ST_DONE:
                if (out_free)
                begin
                    cmd.op         = mexp_pkg::OP_OUT;
                    rsp_valid_next = 1'b1;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    // An accepted request always goes to the modulus check first.
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == mexp_pkg::ST_CHECK)
        else $error("accepted request did not enter modulus check");

    // Leaving DONE always presents a result.
    a_done_presents: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mexp_pkg::ST_DONE && out_free
        |=> rsp_valid_reg && state_reg == mexp_pkg::ST_IDLE)
        else $error("result not presented when leaving DONE");

endmodule

// File: hw/rtl/modular_exponentiation_unit.sv
`timescale 1ns / 1ps
// Top level of the modular exponentiation unit.
//
//  channel | modport | payload                                  | transaction on
//  --------+---------+------------------------------------------+------------------
//  req     | sink    | base_value, exponent, modulus            | valid && ready
//  rsp     | source  | power_result, zero_modulus_error         | valid && ready
//
// One request at a time; the shared shift-add multiplier, one bit per cycle,
// sets the run time. A modulus of 0 or 1 skips all arithmetic.
// rst_n clears the controller and the response valid; no clearing pass.
// A finished result waits in the response register while the next request
// is accepted; a stall on rsp only holds the block in DONE at the end of the
// following request.
module modular_exponentiation_unit #(
    parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mexp_req_if.sink   req,
    mexp_rsp_if.source rsp
);

    mexp_pkg::cmd_t cmd;
    mexp_pkg::sts_t sts;

    // Sequencer: right-to-left square-and-multiply over the exponent bits.
    mexp_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Operands, base reduction, shared modular multiplier, result register.
    mexp_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .base_value         (req.base_value),
        .exponent           (req.exponent),
        .modulus            (req.modulus),
        .power_result       (rsp.power_result),
        .zero_modulus_error (rsp.zero_modulus_error)
    );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the modular exponentiation unit.
module tb_top;

    localparam int W          = mexp_pkg::FIELD_W;
    localparam int OPW        = mexp_pkg::OPERAND_WIDTH_DEF;
    localparam int IDLE_PCT   = 25;
    // Covers the worst request plus a receiver hold-off.
    localparam int QUIET_LIMIT = 40000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [W-1:0] OPERAND_MASK = {W{1'b1}} >> (W - OPW);
    localparam logic [W-1:0] ALL_ONES     = {W{1'b1}};

    typedef struct packed {
        logic [W-1:0] power_result;
        logic         zero_modulus_error;
    } power_rsp_t;

    logic clk;
    logic rst_n;

    mexp_req_if req ();
    mexp_rsp_if rsp ();

    modular_exponentiation_unit #(
        .OPERAND_WIDTH (OPW)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Expected responses, oldest first; one per accepted request.
    power_rsp_t pending_powers[$];
    int         error_count = 0;
    bit         idle_en     = 1'b1;
    int         hold_left   = 0;    // receiver hold-off, in cycles

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Right-to-left square-and-multiply with exact 2W-bit products.
    function automatic power_rsp_t predict_power(logic [W-1:0] b, logic [W-1:0] e,
                                                 logic [W-1:0] m);
        power_rsp_t     r;
        logic [W-1:0]   base_r;
        logic [W-1:0]   expo_r;
        logic [W-1:0]   mod_r;
        logic [W-1:0]   acc;
        logic [W-1:0]   sq;
        logic [2*W-1:0] prod;
        base_r = b & OPERAND_MASK;
        expo_r = e & OPERAND_MASK;
        mod_r  = m & OPERAND_MASK;
        r.power_result       = '0;
        r.zero_modulus_error = 1'b0;
        if (mod_r == '0)
        begin
            r.zero_modulus_error = 1'b1;
            return r;
        end
        if (mod_r == W'(1))
            return r;
        acc = W'(1);
        sq  = base_r % mod_r;
        while (expo_r != '0)
        begin
            if (expo_r[0])
            begin
                prod = ({{W{1'b0}}, acc} * {{W{1'b0}}, sq}) % {{W{1'b0}}, mod_r};
                acc  = prod[W-1:0];
            end
            prod   = ({{W{1'b0}}, sq} * {{W{1'b0}}, sq}) % {{W{1'b0}}, mod_r};
            sq     = prod[W-1:0];
            expo_r = expo_r >> 1;
        end
        r.power_result = acc & OPERAND_MASK;
        return r;
    endfunction

    function automatic logic [W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Drive one request at the falling edge and hold it until the transaction.
    // Called right after a rising edge; leaves valid high for the caller.
    task automatic send_request(logic [W-1:0] b, logic [W-1:0] e, logic [W-1:0] m);
        @(negedge clk);
        while (idle_en && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.base_value <= b;
        req.exponent   <= e;
        req.modulus    <= m;
        do
            @(posedge clk);
        while (!req.ready);
        pending_powers.push_back(predict_power(b, e, m));
    endtask

    // Zero modulus, unit modulus, zero exponent, zero base.
    task automatic test_special_cases();
        send_request(rand_word(), rand_word(), '0);
        send_request(ALL_ONES, ALL_ONES, '0);
        send_request(rand_word(), rand_word(), W'(1));
        send_request(ALL_ONES, ALL_ONES, W'(1));
        send_request(rand_word(), '0, W'(2));
        send_request(ALL_ONES, '0, ALL_ONES);
        send_request('0, '0, W'(7));
        send_request('0, W'(5), W'(7));
        send_request('0, '0, '0);
    endtask

    // Base above the modulus, full-width exponents and moduli.
    task automatic test_operand_extremes();
        send_request(ALL_ONES, W'(3), W'(64'd1000003));
        send_request(ALL_ONES, ALL_ONES, ALL_ONES);
        send_request(ALL_ONES - W'(1), ALL_ONES, ALL_ONES);
        send_request(W'(3), ALL_ONES, W'(1) << (W - 1));
        // Fermat check against the largest 64-bit prime: result is 1.
        send_request(W'(2), W'(64'hFFFF_FFFF_FFFF_FFC4), W'(64'hFFFF_FFFF_FFFF_FFC5));
        send_request(ALL_ONES - W'(1), W'(1), ALL_ONES);
        send_request(ALL_ONES, rand_word(), W'(2));
        send_request(W'(64'h8000_0000_0000_0001), W'(64'h8000_0000_0000_0000), W'(3));
        send_request(rand_word(), W'(64'h5555_5555_5555_5555), rand_word());
        send_request(rand_word(), W'(64'hAAAA_AAAA_AAAA_AAAA), rand_word() | W'(1));
    endtask

    // Receiver stalls for a long stretch while short requests keep coming,
    // so the response register fills and the request side stops accepting.
    task automatic test_backpressure();
        int i;
        hold_left = 600;
        for (i = 0; i < 8; i++)
        begin
            if (i % 3 == 0)
                send_request(rand_word(), rand_word(), W'(i % 2));
            else
                send_request(rand_word(), W'($urandom_range(0, 7)), rand_word());
        end
    endtask

    task automatic test_random_traffic(int count);
        int           i;
        int           sel;
        logic [W-1:0] b;
        logic [W-1:0] e;
        logic [W-1:0] m;
        for (i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 5)
                b = '0;
            else if (sel < 10)
                b = ALL_ONES;
            else
                b = rand_word();
            // Exponent length sets the run time: most are short, some full width.
            sel = $urandom_range(0, 99);
            if (sel < 10)
                e = rand_word();
            else
                e = rand_word() & ((W'(1) << $urandom_range(0, 12)) - W'(1));
            sel = $urandom_range(0, 99);
            if (sel < 5)
                m = '0;
            else if (sel < 10)
                m = W'(1);
            else if (sel < 20)
                m = W'($urandom_range(2, 1000));
            else if (sel < 30)
                m = W'(1) << $urandom_range(1, W - 1);
            else
                m = rand_word() >> $urandom_range(0, 40);
            send_request(b, e, m);
        end
    endtask

    // Back-to-back traffic with neither side idling.
    task automatic test_streaming(int count);
        int i;
        idle_en = 1'b0;
        for (i = 0; i < count; i++)
            send_request(rand_word(), rand_word() & W'(8'hFF),
                         (i % 4 == 0) ? W'(i % 8 == 0) : rand_word());
        idle_en = 1'b1;
    endtask

    // Stimulus sequence and end of run.
    initial
    begin
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.base_value = '0;
        req.exponent   = '0;
        req.modulus    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_operand_extremes();
        test_backpressure();
        test_random_traffic(55);
        test_streaming(20);

        @(negedge clk);
        req.valid <= 1'b0;
        while (pending_powers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Receiver: random ready, or a counted hold-off when one is requested.
    initial
    begin
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp.ready <= !(idle_en && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Response checker: every transaction on rsp against the oldest prediction.
    always @(posedge clk)
    begin
        power_rsp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_powers.size() == 0)
            begin
                $display("%0t unexpected response: power_result %h zero_modulus_error %b",
                         $time, rsp.power_result, rsp.zero_modulus_error);
                error_count++;
            end
            else
            begin
                want = pending_powers.pop_front();
                if (rsp.power_result !== want.power_result)
                begin
                    $display("%0t power_result mismatch: expected %h actual %h",
                             $time, want.power_result, rsp.power_result);
                    error_count++;
                end
                if (rsp.zero_modulus_error !== want.zero_modulus_error)
                begin
                    $display("%0t zero_modulus_error mismatch: expected %b actual %b",
                             $time, want.zero_modulus_error, rsp.zero_modulus_error);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run after too many cycles with no transaction at all.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t watchdog: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

endmodule
